FILE: src/blpe_pkg.sv
// Package for the button long-press event unit.
// Command codes, event codes, the command item and the result item types.
// No dependencies.
package blpe_pkg;

    localparam int HOLD_W = 16;
    localparam int THR_W = 16;
    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;
    localparam logic [THR_W-1:0] THR_RESET = 16'd1000;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POLL  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] index;
        logic       level;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0] event_code;
        logic [7:0] event_index;
        logic       longpress_hit;
        logic       push_dropped;
    } result_t;

endpackage

FILE: src/blpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module blpe_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/blpe_front.sv
// Front end: accepts stream transactions, decodes the command and holds
// them in a two-entry queue toward the back end. Depends on blpe_pkg.
module blpe_front
    import blpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_cmd,
    input  logic [7:0]  in_index,
    input  logic        in_level,
    output logic        cq_valid,
    input  logic        cq_ready,
    output cmd_item_t   cq_item
);

    cmd_item_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    cmd_item_t  new_item;

    assign in_ready = (cnt_reg != 2'd2);
    assign cq_valid = (cnt_reg != 2'd0);
    assign cq_item  = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = cq_valid && cq_ready;

    always_comb
    begin
        new_item.cmd   = cmd_t'(in_cmd);
        new_item.index = in_index;
        new_item.level = in_level;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: src/blpe_back.sv
// Back end: event queue, per-button channel state, threshold register and
// result register. Depends on blpe_pkg and blpe_ram.
module blpe_back
    import blpe_pkg::*;
#(
    parameter int NUM_BUTTONS = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [THR_W-1:0] cfg_wdata,
    input  logic             cq_valid,
    output logic             cq_ready,
    input  cmd_item_t        cq_item,
    output logic             res_valid,
    input  logic             res_ready,
    output result_t          res
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [7:0] NB = 8'(NUM_BUTTONS);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_POLL = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [THR_W-1:0]  thr_reg;
    logic              pressed_reg [NUM_BUTTONS];
    logic              pressed_next [NUM_BUTTONS];
    logic              fired_reg [NUM_BUTTONS];
    logic              fired_next [NUM_BUTTONS];
    logic [HOLD_W-1:0] hold_reg [NUM_BUTTONS];
    logic [HOLD_W-1:0] hold_next [NUM_BUTTONS];
    logic              out_valid_reg, out_valid_next;
    result_t           res_reg, res_next;
    logic              load;

    logic              ram_we, ram_re;
    logic [8:0]        ram_wdata, ram_rdata;
    logic [7:0]        ev_index;
    logic              ev_level;
    logic [IDX_W-1:0]  ev_sel, q_sel;
    logic              q_in_range;

    blpe_ram #(
        .WIDTH (9),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign cq_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || res_ready);
    assign res_valid  = out_valid_reg;
    assign res        = res_reg;
    assign ram_wdata  = {cq_item.level, cq_item.index};
    assign ev_index   = ram_rdata[7:0];
    assign ev_level   = ram_rdata[8];
    assign ev_sel     = ev_index[IDX_W-1:0];
    assign q_sel      = cq_item.index[IDX_W-1:0];
    assign q_in_range = (cq_item.index < NB);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        res_next   = '0;
        load       = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            pressed_next[i] = pressed_reg[i];
            fired_next[i]   = fired_reg[i];
            hold_next[i]    = hold_reg[i];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cq_valid && cq_ready)
                begin
                    unique case (cq_item.cmd)
                        CMD_PUSH:
                        begin
                            load = 1'b1;
                            if (count_reg == CNT_FULL)
                            begin
                                res_next.push_dropped = 1'b1;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                tail_next  = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_POLL:
                        begin
                            if (count_reg != '0)
                            begin
                                ram_re     = 1'b1;
                                head_next  = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                                count_next = count_reg - 1'b1;
                                state_next = ST_POLL;
                            end
                            else
                            begin
                                load = 1'b1;
                            end
                        end
                        CMD_TICK:
                        begin
                            load = 1'b1;
                            for (int i = 0; i < NUM_BUTTONS; i++)
                            begin
                                if (pressed_reg[i] && hold_reg[i] != HOLD_MAX)
                                begin
                                    hold_next[i] = hold_reg[i] + 1'b1;
                                end
                            end
                        end
                        CMD_QUERY:
                        begin
                            load = 1'b1;
                            if (q_in_range && pressed_reg[q_sel] && !fired_reg[q_sel]
                                && hold_reg[q_sel] >= thr_reg)
                            begin
                                fired_next[q_sel]      = 1'b1;
                                res_next.longpress_hit = 1'b1;
                            end
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            ST_POLL:
            begin
                load       = 1'b1;
                state_next = ST_IDLE;
                if (ev_index < NB)
                begin
                    res_next.event_index = ev_index;
                    for (int i = 0; i < NUM_BUTTONS; i++)
                    begin
                        if (IDX_W'(i) == ev_sel)
                        begin
                            hold_next[i]    = '0;
                            pressed_next[i] = !ev_level;
                            if (!ev_level)
                            begin
                                fired_next[i] = 1'b0;
                            end
                        end
                    end
                    res_next.event_code = ev_level ? EV_RELEASE : EV_PRESS;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = (out_valid_reg && !res_ready) || load;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            thr_reg       <= THR_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                pressed_reg[i] <= 1'b0;
                fired_reg[i]   <= 1'b0;
                hold_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                pressed_reg[i] <= pressed_next[i];
                fired_reg[i]   <= fired_next[i];
                hold_reg[i]    <= hold_next[i];
            end
        end
    end

endmodule

FILE: src/button_longpress_event_unit.sv
// Top level of the button long-press event unit.
// Instantiates blpe_front and blpe_back; depends on blpe_pkg.
//
//  channel   direction  handshake                  payload
//  s_axis    in         s_axis_tvalid/tready       tuser: cmd; tdata: index, level
//  m_axis    out        m_axis_tvalid/tready       tuser: event_code; tdata: rest
//  cfg       in         cfg_we                     cfg_wdata: longpress threshold
//
// Push, tick and query complete in the back end's idle state; a poll of a non-empty
// queue also passes through ST_POLL for the registered read of the event queue RAM.
// A transaction is registered in the command queue and then in the result register.
// Reset clears all control and channel state; no clearing pass is needed.
// A stalled output holds the result register; the two-entry command queue
// keeps accepting until it fills.
module button_longpress_event_unit
    import blpe_pkg::*;
#(
    parameter int NUM_BUTTONS = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] button_index, [8] level
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] event_index, [8] longpress_hit,
                                        // [9] push_dropped
    output logic [1:0]  m_axis_tuser    // [1:0] event_code
);

    logic      cq_valid, cq_ready;
    cmd_item_t cq_item;
    result_t   res;

    blpe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (s_axis_tuser),
        .in_index (s_axis_tdata[7:0]),
        .in_level (s_axis_tdata[8]),
        .cq_valid (cq_valid),
        .cq_ready (cq_ready),
        .cq_item  (cq_item)
    );

    blpe_back #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cq_valid  (cq_valid),
        .cq_ready  (cq_ready),
        .cq_item   (cq_item),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tuser = res.event_code;
    assign m_axis_tdata = {6'd0, res.push_dropped, res.longpress_hit, res.event_index};

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for button_longpress_event_unit: directed table, then random
// command streams under several thresholds, including a long-hold run.
// Depends on blpe_pkg and the RTL of the unit; needs nothing else.
`timescale 1ns / 100ps

module testbench
    import blpe_pkg::*;
();

    localparam int NUM_BUTTONS = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 380;
    localparam int REPORT_CAP = 40;

    typedef struct {
        cmd_t       cmd;
        logic [7:0] index;
        logic       level;
        bit         fixed;
        result_t    want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // predictor state
    logic [8:0]  fifo_mem [QUEUE_DEPTH];
    int unsigned fifo_head;
    int unsigned fifo_tail;
    int unsigned fifo_count;
    bit          pressed [NUM_BUTTONS];
    logic [15:0] hold [NUM_BUTTONS];
    bit          fired [NUM_BUTTONS];
    logic [15:0] threshold_q;

    result_t     pending_results [$];
    stim_row_t   press_table [$];
    result_t     oldest;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int          burst_left = 0;
    int          rx_hold = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;

    button_longpress_event_unit #(
        .NUM_BUTTONS(NUM_BUTTONS),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),    // [7:0] button_index, [8] level
        .s_axis_tuser(s_axis_tuser),    // [1:0] cmd
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),    // [7:0] event_index, [8] longpress_hit, [9] push_dropped
        .m_axis_tuser(m_axis_tuser)     // [1:0] event_code
    );

    always #1 clk = ~clk;

    function automatic result_t button_step(cmd_t cmd, logic [7:0] index, logic level);
        result_t    r;
        logic [8:0] entry;
        r = '0;
        case (cmd)
            CMD_PUSH:
            begin
                if (fifo_count >= QUEUE_DEPTH)
                begin
                    r.push_dropped = 1'b1;
                end
                else
                begin
                    fifo_mem[fifo_tail] = {level, index};
                    fifo_tail = (fifo_tail + 1) % QUEUE_DEPTH;
                    fifo_count++;
                end
            end
            CMD_POLL:
            begin
                if (fifo_count > 0)
                begin
                    entry = fifo_mem[fifo_head];
                    fifo_head = (fifo_head + 1) % QUEUE_DEPTH;
                    fifo_count--;
                    if (entry[7:0] < NUM_BUTTONS)
                    begin
                        hold[entry[7:0]] = '0;
                        if (!entry[8])
                        begin
                            pressed[entry[7:0]] = 1'b1;
                            fired[entry[7:0]] = 1'b0;
                            r.event_code = EV_PRESS;
                        end
                        else
                        begin
                            pressed[entry[7:0]] = 1'b0;
                            r.event_code = EV_RELEASE;
                        end
                        r.event_index = entry[7:0];
                    end
                end
            end
            CMD_TICK:
            begin
                for (int i = 0; i < NUM_BUTTONS; i++)
                begin
                    if (pressed[i] && hold[i] != HOLD_MAX)
                        hold[i] = hold[i] + 16'd1;
                end
            end
            default:
            begin
                if (index < NUM_BUTTONS && pressed[index] && !fired[index]
                    && hold[index] >= threshold_q)
                begin
                    fired[index] = 1'b1;
                    r.longpress_hit = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    // mostly no pause, some short, a few long
    function automatic int pause_length(int none_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < none_pct)
            return 0;
        else if (r < none_pct + (100 - none_pct) * 3 / 4)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic check_field(string field, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v)
        begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t: %s expected %0d actual %0d", $realtime, field, want_v, got_v);
        end
    endtask

    task automatic add_row(cmd_t cmd, logic [7:0] index, logic level, bit fixed,
                           logic [1:0] code, logic [7:0] ev_index, logic hit, logic dropped);
        stim_row_t row;
        row.cmd = cmd;
        row.index = index;
        row.level = level;
        row.fixed = fixed;
        row.want.event_code = code;
        row.want.event_index = ev_index;
        row.want.longpress_hit = hit;
        row.want.push_dropped = dropped;
        press_table.push_back(row);
    endtask

    task automatic send_item(cmd_t cmd, logic [7:0] index, logic level, bit fixed,
                             result_t want);
        result_t predicted;
        int      gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {7'd0, level, index};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = button_step(cmd, index, level);
        pending_results.push_back(fixed ? want : predicted);
        gap = tx_calm ? 0 : pause_length(70);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_threshold(logic [15:0] value);
        drain_results();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        threshold_q = value;
    endtask

    task automatic random_item();
        cmd_t       cmd;
        logic [7:0] index;
        logic       level;
        int         r;
        r = $urandom_range(0, 99);
        if (burst_left > 0)
        begin
            burst_left--;
            cmd = CMD_PUSH;
        end
        else if (r < 2)
        begin
            // push burst: fills the event queue and forces drops
            burst_left = $urandom_range(16, 22);
            cmd = CMD_PUSH;
        end
        else if (r < 30)
            cmd = CMD_PUSH;
        else if (r < 58)
            cmd = CMD_POLL;
        else if (r < 85)
            cmd = CMD_TICK;
        else
            cmd = CMD_QUERY;
        if ($urandom_range(0, 99) < 88)
            index = 8'($urandom_range(0, NUM_BUTTONS - 1));
        else
            index = 8'($urandom_range(0, 255));
        level = 1'($urandom_range(0, 1));
        send_item(cmd, index, level, 1'b0, '0);
    endtask

    task automatic random_phase(logic [15:0] thr, int count);
        set_threshold(thr);
        for (int n = 0; n < count; n++)
        begin
            if (n % 150 == 0)
            begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            random_item();
        end
    endtask

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!rx_calm)
                rx_hold = pause_length(80);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: unexpected transaction, expected none, actual code %0d index %0d",
                             $realtime, m_axis_tuser, m_axis_tdata[7:0]);
            end
            else
            begin
                oldest = pending_results.pop_front();
                check_field("event_code", oldest.event_code, m_axis_tuser);
                check_field("event_index", oldest.event_index, m_axis_tdata[7:0]);
                check_field("longpress_hit", oldest.longpress_hit, m_axis_tdata[8]);
                check_field("push_dropped", oldest.push_dropped, m_axis_tdata[9]);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_PUSH;
        m_axis_tready = 1'b0;
        fifo_head = 0;
        fifo_tail = 0;
        fifo_count = 0;
        threshold_q = THR_RESET;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            pressed[i] = 1'b0;
            hold[i] = '0;
            fired[i] = 1'b0;
        end

        // threshold stays at its reset value for the table
        add_row(CMD_POLL,  8'd255, 1'b1, 1'b1, EV_NONE,    8'd0, 1'b0, 1'b0);
        add_row(CMD_QUERY, 8'd0,   1'b0, 1'b1, EV_NONE,    8'd0, 1'b0, 1'b0);
        add_row(CMD_TICK,  8'd0,   1'b0, 1'b1, EV_NONE,    8'd0, 1'b0, 1'b0);
        add_row(CMD_PUSH,  8'd0,   1'b0, 1'b1, EV_NONE,    8'd0, 1'b0, 1'b0);
        add_row(CMD_PUSH,  8'd255, 1'b1, 1'b1, EV_NONE,    8'd0, 1'b0, 1'b0);
        add_row(CMD_PUSH,  8'd7,   1'b0, 1'b1, EV_NONE,    8'd0, 1'b0, 1'b0);
        add_row(CMD_PUSH,  8'd8,   1'b0, 1'b1, EV_NONE,    8'd0, 1'b0, 1'b0);
        add_row(CMD_PUSH,  8'd0,   1'b1, 1'b1, EV_NONE,    8'd0, 1'b0, 1'b0);
        add_row(CMD_POLL,  8'd0,   1'b0, 1'b1, EV_PRESS,   8'd0, 1'b0, 1'b0);
        add_row(CMD_POLL,  8'd0,   1'b0, 1'b1, EV_NONE,    8'd0, 1'b0, 1'b0);
        add_row(CMD_POLL,  8'd0,   1'b0, 1'b1, EV_PRESS,   8'd7, 1'b0, 1'b0);
        add_row(CMD_POLL,  8'd0,   1'b0, 1'b1, EV_NONE,    8'd0, 1'b0, 1'b0);
        add_row(CMD_TICK,  8'd0,   1'b0, 1'b0, EV_NONE,    8'd0, 1'b0, 1'b0);
        add_row(CMD_QUERY, 8'd7,   1'b0, 1'b1, EV_NONE,    8'd0, 1'b0, 1'b0);
        add_row(CMD_QUERY, 8'd255, 1'b0, 1'b1, EV_NONE,    8'd0, 1'b0, 1'b0);
        add_row(CMD_POLL,  8'd0,   1'b0, 1'b1, EV_RELEASE, 8'd0, 1'b0, 1'b0);
        add_row(CMD_PUSH,  8'd7,   1'b1, 1'b1, EV_NONE,    8'd0, 1'b0, 1'b0);
        add_row(CMD_PUSH,  8'd170, 1'b1, 1'b1, EV_NONE,    8'd0, 1'b0, 1'b0);
        add_row(CMD_PUSH,  8'd85,  1'b0, 1'b1, EV_NONE,    8'd0, 1'b0, 1'b0);
        add_row(CMD_POLL,  8'd0,   1'b0, 1'b1, EV_RELEASE, 8'd7, 1'b0, 1'b0);
        add_row(CMD_POLL,  8'd0,   1'b0, 1'b1, EV_NONE,    8'd0, 1'b0, 1'b0);
        add_row(CMD_POLL,  8'd0,   1'b0, 1'b1, EV_NONE,    8'd0, 1'b0, 1'b0);
        add_row(CMD_POLL,  8'd0,   1'b0, 1'b1, EV_NONE,    8'd0, 1'b0, 1'b0);
        add_row(CMD_QUERY, 8'd0,   1'b0, 1'b0, EV_NONE,    8'd0, 1'b0, 1'b0);
        add_row(CMD_TICK,  8'd0,   1'b0, 1'b0, EV_NONE,    8'd0, 1'b0, 1'b0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (press_table[k])
            send_item(press_table[k].cmd, press_table[k].index, press_table[k].level,
                      press_table[k].fixed, press_table[k].want);

        random_phase(16'd0, PHASE_ITEMS);
        random_phase(16'd3, PHASE_ITEMS);
        random_phase(16'($urandom_range(1, 20)), PHASE_ITEMS);
        random_phase(16'd12, PHASE_ITEMS);
        random_phase(16'd1, PHASE_ITEMS);

        // long hold crossing the threshold on two channels
        set_threshold(16'd40);
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        send_item(CMD_PUSH, 8'd3, 1'b0, 1'b0, '0);
        send_item(CMD_PUSH, 8'd4, 1'b0, 1'b0, '0);
        send_item(CMD_POLL, 8'd0, 1'b0, 1'b0, '0);
        send_item(CMD_POLL, 8'd0, 1'b0, 1'b0, '0);
        repeat (39) send_item(CMD_TICK, 8'd0, 1'b0, 1'b0, '0);
        send_item(CMD_QUERY, 8'd3, 1'b0, 1'b0, '0);
        send_item(CMD_TICK, 8'd0, 1'b0, 1'b0, '0);
        send_item(CMD_QUERY, 8'd3, 1'b0, 1'b0, '0);
        repeat (5) send_item(CMD_TICK, 8'd0, 1'b0, 1'b0, '0);
        send_item(CMD_QUERY, 8'd4, 1'b0, 1'b0, '0);
        send_item(CMD_QUERY, 8'd4, 1'b0, 1'b0, '0);
        send_item(CMD_PUSH, 8'd3, 1'b1, 1'b0, '0);
        send_item(CMD_POLL, 8'd0, 1'b0, 1'b0, '0);
        send_item(CMD_QUERY, 8'd3, 1'b0, 1'b0, '0);

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: button_longpress_event_unit.f
src/blpe_pkg.sv
src/blpe_ram.sv
src/blpe_front.sv
src/blpe_back.sv
src/button_longpress_event_unit.sv
tb/sv/testbench.sv
